// ----- src/fat12_cluster_table_engine_unit_macros.svh -----
// Assertion macros used by the checker file of the cluster table engine.
`ifndef FAT12_CLUSTER_TABLE_ENGINE_UNIT_MACROS_SVH
`define FAT12_CLUSTER_TABLE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define FCTBL_ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("fctbl assertion failed");

// Next-cycle implication, disabled while dis is high.
`define FCTBL_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("fctbl assertion failed");

`endif

// ----- src/fctbl_pkg.sv -----
`default_nettype none

package fctbl_pkg;

    // Table store size in bytes and its address width
    localparam int TABLE_BYTES = 6144;
    localparam int ADDR_W      = $clog2(TABLE_BYTES);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Entry classes
    localparam logic [11:0] ENT_FREE     = 12'h000;
    localparam logic [11:0] ENT_RESERVED = 12'hFF0;
    localparam logic [11:0] ENT_END      = 12'hFFF;
    localparam logic [11:0] ENT_END_MIN  = 12'hFF8;

    // Nibble masks
    localparam logic [7:0] LO_NIB = 8'h0F;
    localparam logic [7:0] HI_NIB = 8'hF0;

    typedef enum logic [1:0] {
        FN_GET  = 2'd0,
        FN_SET  = 2'd1,
        FN_WALK = 2'd2,
        FN_LOAD = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_ERR = 2'd1,
        ST_END = 2'd2
    } status_t;

    // What the back end has to do with a queued command
    typedef enum logic [2:0] {
        K_DONE = 3'd0,
        K_GET  = 3'd1,
        K_SET  = 3'd2,
        K_WALK = 3'd3,
        K_LOAD = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [11:0]       cluster;
        logic [ADDR_W-1:0] addr;
        logic [11:0]       value;
        logic [11:0]       steps;
        logic [7:0]        data;
        status_t           status;
    } cmd_t;

    // Cluster lies inside the volume and both of its bytes inside the store
    function automatic logic cluster_ok(input logic [11:0] n,
                                        input logic [15:0] ts,
                                        input logic [7:0]  fds);
        logic [16:0] lhs;
        logic [16:0] rhs;
        logic [13:0] last;
        lhs  = 17'(n) + 17'(fds);
        rhs  = 17'(ts) + 17'd2;
        last = 14'(n) + 14'(n[11:1]) + 14'd1;
        return (lhs <= rhs) && (32'(last) < 32'(TABLE_BYTES));
    endfunction

    // First byte of the entry: floor(3n/2)
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [11:0] n);
        logic [13:0] a;
        a = 14'(n) + 14'(n[11:1]);
        return a[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/fctbl_front.sv -----
`default_nettype none

module fctbl_front (
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    // cluster_index[11:0], new_value[23:12], step_count[35:24],
    // byte_address[48:36], byte_data[56:49], zero fill
    input  wire logic [63:0]     s_tdata,
    // func[1:0]
    input  wire logic [1:0]      s_tuser,
    input  wire logic [15:0]     total_sectors,
    input  wire logic [7:0]      first_data_sector,
    input  wire logic            busy,
    input  wire logic            q_ready,
    output logic                 q_push,
    output fctbl_pkg::cmd_t      q_cmd
);
    import fctbl_pkg::*;

    logic [11:0] cluster;
    logic [11:0] new_value;
    logic [11:0] steps;
    logic [12:0] byte_address;
    logic [7:0]  byte_data;
    logic        in_range;

    assign cluster      = s_tdata[11:0];
    assign new_value    = s_tdata[23:12];
    assign steps        = s_tdata[35:24];
    assign byte_address = s_tdata[48:36];
    assign byte_data    = s_tdata[56:49];

    assign s_tready = !busy && q_ready;
    assign q_push   = s_tvalid && s_tready;

    assign in_range = cluster_ok(cluster, total_sectors, first_data_sector);

    // Sort each beat: answer early cases here, hand the rest to the back end
    always_comb begin
        q_cmd.kind    = K_DONE;
        q_cmd.cluster = cluster;
        q_cmd.addr    = entry_addr(cluster);
        q_cmd.value   = 12'd0;
        q_cmd.steps   = steps;
        q_cmd.data    = byte_data;
        q_cmd.status  = ST_OK;
        case (func_t'(s_tuser))
            FN_GET: begin
                if (in_range) begin
                    q_cmd.kind = K_GET;
                end else begin
                    q_cmd.status = ST_ERR;
                end
            end
            FN_SET: begin
                // a refused set reports entry zero
                if (in_range) begin
                    q_cmd.kind  = K_SET;
                    q_cmd.value = new_value;
                end else begin
                    q_cmd.status = ST_ERR;
                end
            end
            FN_WALK: begin
                q_cmd.value = cluster;
                if (steps == 12'd0) begin
                    q_cmd.status = ST_OK;
                end else if (!in_range) begin
                    q_cmd.status = ST_ERR;
                end else begin
                    q_cmd.kind = K_WALK;
                end
            end
            FN_LOAD: begin
                if (32'(byte_address) < 32'(TABLE_BYTES)) begin
                    q_cmd.kind = K_LOAD;
                    q_cmd.addr = byte_address[ADDR_W-1:0];
                end else begin
                    q_cmd.status = ST_ERR;
                end
            end
            default: begin
                q_cmd.status = ST_ERR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/fctbl_queue.sv -----
`default_nettype none

module fctbl_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire fctbl_pkg::cmd_t push_cmd,
    output logic                 ready,
    input  wire logic            pop,
    output fctbl_pkg::cmd_t      pop_cmd,
    output logic                 valid
);
    import fctbl_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign valid   = (count_reg != '0);
    assign ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // Pointer and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/fctbl_back.sv -----
`default_nettype none

module fctbl_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [15:0]     total_sectors,
    input  wire logic [7:0]      first_data_sector,
    input  wire logic            q_valid,
    input  wire fctbl_pkg::cmd_t q_cmd,
    output logic                 q_pop,
    output logic                 busy,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    // entry[11:0], zero fill
    output logic [15:0]          m_tdata,
    // status[1:0]
    output logic [1:0]           m_tuser
);
    import fctbl_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD_LO = 8'b0000_0100,
        S_RD_HI = 8'b0000_1000,
        S_EVAL  = 8'b0001_0000,
        S_WR_LO = 8'b0010_0000,
        S_WR_HI = 8'b0100_0000,
        S_LINK  = 8'b1000_0000
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_BYTES - 1);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    kind_t             kind_reg, kind_next;
    logic [11:0]       cur_reg, cur_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [11:0]       val_reg, val_next;
    logic [11:0]       steps_reg, steps_next;
    logic [7:0]        lo_reg, lo_next;
    logic [7:0]        wlo_reg, wlo_next;
    logic [7:0]        whi_reg, whi_next;
    logic              out_valid_reg, out_valid_next;
    logic [11:0]       out_entry_reg, out_entry_next;
    status_t           out_status_reg, out_status_next;

    logic [7:0]        table_mem [TABLE_BYTES];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              out_free;
    logic              fin;
    logic [11:0]       fin_entry;
    status_t           fin_status;
    logic [11:0]       raw;
    logic [11:0]       cls;

    // Even entry: low byte plus low nibble of the next; odd: high nibble plus next byte
    function automatic logic [11:0] assemble(input logic [7:0] lo, input logic [7:0] hi,
                                             input logic odd);
        return odd ? {hi, lo[7:4]} : {hi[3:0], lo};
    endfunction

    function automatic logic [11:0] classify(input logic [11:0] v);
        logic [11:0] r;
        if (v >= ENT_END_MIN) begin
            r = ENT_END;
        end else if (v >= ENT_RESERVED) begin
            r = ENT_RESERVED;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign busy     = (state_reg == S_CLEAR);
    assign out_free = !out_valid_reg || m_tready;
    assign raw      = assemble(lo_reg, rdata_reg, cur_reg[0]);
    assign cls      = classify(raw);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_entry_reg};
    assign m_tuser  = out_status_reg;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        kind_next     = kind_reg;
        cur_next      = cur_reg;
        addr_next     = addr_reg;
        val_next      = val_reg;
        steps_next    = steps_reg;
        lo_next       = lo_reg;
        wlo_next      = wlo_reg;
        whi_next      = whi_reg;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = 8'h00;
        mem_re        = 1'b0;
        mem_raddr     = addr_reg;
        q_pop         = 1'b0;
        fin           = 1'b0;
        fin_entry     = 12'd0;
        fin_status    = ST_OK;
        case (state_reg)
            // zero the store after reset, one byte a cycle
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.kind)
                        K_DONE: begin
                            if (out_free) begin
                                q_pop      = 1'b1;
                                fin        = 1'b1;
                                fin_entry  = q_cmd.value;
                                fin_status = q_cmd.status;
                            end
                        end
                        K_LOAD: begin
                            if (out_free) begin
                                q_pop     = 1'b1;
                                fin       = 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = q_cmd.addr;
                                mem_wdata = q_cmd.data;
                            end
                        end
                        K_GET, K_SET, K_WALK: begin
                            q_pop      = 1'b1;
                            kind_next  = q_cmd.kind;
                            cur_next   = q_cmd.cluster;
                            addr_next  = q_cmd.addr;
                            val_next   = q_cmd.value;
                            steps_next = q_cmd.steps;
                            state_next = S_RD_LO;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_LO: begin
                mem_re     = 1'b1;
                state_next = S_RD_HI;
            end
            S_RD_HI: begin
                mem_re     = 1'b1;
                mem_raddr  = addr_reg + ADDR_W'(1);
                lo_next    = rdata_reg;
                state_next = S_EVAL;
            end
            // both bytes in hand: lo_reg and rdata_reg
            S_EVAL: begin
                case (kind_reg)
                    K_GET: begin
                        if (out_free) begin
                            fin        = 1'b1;
                            fin_entry  = cls;
                            state_next = S_IDLE;
                        end
                    end
                    K_SET: begin
                        if (cur_reg[0]) begin
                            wlo_next = (lo_reg & LO_NIB) | ({val_reg[3:0], 4'd0} & HI_NIB);
                            whi_next = val_reg[11:4];
                        end else begin
                            wlo_next = val_reg[7:0];
                            whi_next = (rdata_reg & HI_NIB) | {4'd0, val_reg[11:8]};
                        end
                        state_next = S_WR_LO;
                    end
                    K_WALK: begin
                        if (cls == ENT_FREE || cls == ENT_RESERVED) begin
                            if (out_free) begin
                                fin        = 1'b1;
                                fin_entry  = cur_reg;
                                fin_status = ST_ERR;
                                state_next = S_IDLE;
                            end
                        end else if (cls == ENT_END) begin
                            if (out_free) begin
                                fin        = 1'b1;
                                fin_entry  = cur_reg;
                                fin_status = ST_END;
                                state_next = S_IDLE;
                            end
                        end else if (steps_reg == 12'd1) begin
                            if (out_free) begin
                                fin        = 1'b1;
                                fin_entry  = cls;
                                state_next = S_IDLE;
                            end
                        end else begin
                            cur_next   = cls;
                            steps_next = steps_reg - 12'd1;
                            state_next = S_LINK;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WR_LO: begin
                mem_we     = 1'b1;
                mem_wdata  = wlo_reg;
                state_next = S_WR_HI;
            end
            S_WR_HI: begin
                if (out_free) begin
                    mem_we     = 1'b1;
                    mem_waddr  = addr_reg + ADDR_W'(1);
                    mem_wdata  = whi_reg;
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // range check of the next link before reading it
            S_LINK: begin
                if (!cluster_ok(cur_reg, total_sectors, first_data_sector)) begin
                    if (out_free) begin
                        fin        = 1'b1;
                        fin_entry  = cur_reg;
                        fin_status = ST_ERR;
                        state_next = S_IDLE;
                    end
                end else begin
                    addr_next  = entry_addr(cur_reg);
                    state_next = S_RD_LO;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_entry_next  = out_entry_reg;
        out_status_next = out_status_reg;
        if (fin) begin
            out_valid_next  = 1'b1;
            out_entry_next  = fin_entry;
            out_status_next = fin_status;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        cur_reg        <= cur_next;
        addr_reg       <= addr_next;
        val_reg        <= val_next;
        steps_reg      <= steps_next;
        lo_reg         <= lo_next;
        wlo_reg        <= wlo_next;
        whi_reg        <= whi_next;
        out_entry_reg  <= out_entry_next;
        out_status_reg <= out_status_next;
    end

    // Table store: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= table_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/fat12_cluster_table_engine_unit.sv -----
// FAT12 cluster table engine. Holds the table as a 6144-byte store with 12-bit
// entries packed two to three bytes, and serves get, set, chain walk and raw
// byte load commands, one result beat per command beat, in order. After reset
// the store is swept to zero, one byte a cycle, and s_tready stays low for that
// time; configuration writes are taken throughout. All table work goes through
// the store's write and read ports: a get reads two bytes and evaluates them,
// a set also writes both bytes back, raw loads and range-refused commands
// finish straight from idle, and a walk does two byte reads, one evaluation
// and one range check per link. A two-deep command queue lets the next beat be
// taken while a command runs; the output register holds a result until taken.
`default_nettype none

module fat12_cluster_table_engine_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // command channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cluster_index[11:0], new_value[23:12], step_count[35:24],
    // byte_address[48:36], byte_data[56:49], zero fill
    input  wire logic [63:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // entry[11:0], zero fill
    output logic [15:0]      m_tdata,
    // status[1:0]
    output logic [1:0]       m_tuser,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fctbl_pkg::*;

    localparam logic REG_TOTAL_SECTORS     = 1'b0;
    localparam logic REG_FIRST_DATA_SECTOR = 1'b1;

    logic [15:0] total_sectors_reg, total_sectors_next;
    logic [7:0]  first_data_sector_reg, first_data_sector_next;
    logic        cfg_write;

    logic        busy;
    logic        q_ready;
    logic        q_push;
    logic        q_valid;
    logic        q_pop;
    cmd_t        push_cmd;
    cmd_t        pop_cmd;

    // Register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        total_sectors_next     = total_sectors_reg;
        first_data_sector_next = first_data_sector_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_TOTAL_SECTORS:     total_sectors_next     = pwdata[15:0];
                REG_FIRST_DATA_SECTOR: first_data_sector_next = pwdata[7:0];
                default:               total_sectors_next     = total_sectors_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TOTAL_SECTORS:     prdata = {16'd0, total_sectors_reg};
            REG_FIRST_DATA_SECTOR: prdata = {24'd0, first_data_sector_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_sectors_reg     <= 16'd2880;
            first_data_sector_reg <= 8'd33;
        end else begin
            total_sectors_reg     <= total_sectors_next;
            first_data_sector_reg <= first_data_sector_next;
        end
    end

    fctbl_front u_front (
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .total_sectors     (total_sectors_reg),
        .first_data_sector (first_data_sector_reg),
        .busy              (busy),
        .q_ready           (q_ready),
        .q_push            (q_push),
        .q_cmd             (push_cmd)
    );

    fctbl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .valid    (q_valid)
    );

    fctbl_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .total_sectors     (total_sectors_reg),
        .first_data_sector (first_data_sector_reg),
        .q_valid           (q_valid),
        .q_cmd             (pop_cmd),
        .q_pop             (q_pop),
        .busy              (busy),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser)
    );

endmodule

`default_nettype wire

// ----- src/fctbl_checker.sv -----
`default_nettype none
`include "fat12_cluster_table_engine_unit_macros.svh"

module fctbl_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        pready
);
    import fctbl_pkg::*;

    // a stalled result beat stays put
    `FCTBL_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // only defined status codes leave the block
    `FCTBL_ASSERT_NOW(a_status_legal, aclk, !aresetn, m_tvalid, m_tuser == ST_OK || m_tuser == ST_ERR || m_tuser == ST_END)

    // reset starts the clearing sweep: no command beat is taken
    `FCTBL_ASSERT_NEXT(a_reset_blocks_in, aclk, 1'b0, !aresetn, !s_tready)

    // reset drops any pending result
    `FCTBL_ASSERT_NEXT(a_reset_drops_out, aclk, 1'b0, !aresetn, !m_tvalid)

    // configuration port never waits
    `FCTBL_ASSERT_NOW(a_pready_high, aclk, !aresetn, 1'b1, pready)

endmodule

bind fat12_cluster_table_engine_unit fctbl_checker u_fctbl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

`default_nettype wire
